// ===== rtl/sha256_stream_hasher_defines.svh =====
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/sha_pkg.sv =====
// package with sha-256 constants, types and round functions
`timescale 1ns / 1ps
package sha_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} sha_state_t;

	typedef logic [31:0] word_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic word_t rotr(input word_t v, input int unsigned s);
		rotr = (v >> s) | (v << (32 - s));
	endfunction

	function automatic word_t sig0(input word_t v);
		sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic word_t sig1(input word_t v);
		sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic word_t ep0(input word_t v);
		ep0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic word_t ep1(input word_t v);
		ep1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction
endpackage

// ===== rtl/sha_byte_if.sv =====
// input channel: at most one message byte per transaction
`timescale 1ns / 1ps
interface sha_byte_if;
	logic valid;
	logic ready;
	logic [7:0] msg_byte;
	logic byte_valid;
	logic last;
	modport source (output valid, msg_byte, byte_valid, last, input ready);
	modport sink (input valid, msg_byte, byte_valid, last, output ready);
endinterface

// ===== rtl/sha_digest_if.sv =====
// output channel: one digest word per transaction
`timescale 1ns / 1ps
interface sha_digest_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha256_stream_hasher.sv =====
// sha-256 stream hasher: byte buffer, iterative round unit, digest output
// a byte that fills a block starts the 64 rounds, then the add, then the return to idle;
// other bytes leave it in idle; last adds one or two pad blocks, then 8 output words
// throughput: one byte per cycle except while a block is hashed or the digest is sent, one round unit shared
// reset: chaining words to initial values, byte count zero, buffer not cleared
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_byte_if.sink in_ch,
	sha_digest_if.source out_ch
);
	import sha_pkg::*;

	sha_state_t state_q, state_d;
	word_t h_q [8];
	word_t v_q [8];
	word_t w_q [16];
	logic [63:0] count_q;
	logic [5:0] round_q;
	logic final_q;
	logic second_q;
	logic padded_q;
	logic [2:0] out_idx_q;
	logic [5:0] pad_pos_q;

	logic acc;
	logic [5:0] pos;
	logic [63:0] count_inc;
	logic [63:0] bits;
	word_t w_new, t1, t2;
	logic need_two;

	assign acc = in_ch.valid && in_ch.ready;
	assign pos = count_q[5:0];
	assign count_inc = count_q + 64'd1;
	assign bits = {count_q[60:0], 3'b000};
	assign w_new = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
	assign t1 = v_q[7] + ep1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[round_q] + w_q[0];
	assign t2 = ep0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	// padded byte count reaching past the length field needs a second block
	assign need_two = (pad_pos_q > LEN_POS - 6'd1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_ch.byte_valid && pos == 6'd63) state_d = ST_ROUND;
					else if (in_ch.last) state_d = ST_PAD;
				end
			end
			ST_PAD: state_d = ST_ROUND;
			ST_ROUND: if (round_q == 6'd63) state_d = ST_ADD;
			// a final byte that filled a block still needs its padding block
			ST_ADD: begin
				if (!final_q) state_d = ST_IDLE;
				else if (second_q || !padded_q) state_d = ST_PAD;
				else state_d = ST_OUT;
			end
			ST_OUT: if (out_ch.ready && out_idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT);
		out_ch.digest_word = h_q[out_idx_q];
		out_ch.word_index = out_idx_q;
		out_ch.last_word = (out_idx_q == 3'd7);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			round_q <= '0;
			final_q <= 1'b0;
			second_q <= 1'b0;
			padded_q <= 1'b0;
			out_idx_q <= '0;
			pad_pos_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					out_idx_q <= '0;
					if (acc) begin
						final_q <= in_ch.last;
						padded_q <= 1'b0;
						if (in_ch.byte_valid) begin
							count_q <= count_inc;
							pad_pos_q <= count_inc[5:0];
						end else begin
							pad_pos_q <= pos;
						end
					end
				end
				ST_PAD: begin
					second_q <= need_two && !second_q;
					padded_q <= 1'b1;
				end
				ST_ROUND: round_q <= round_q + 6'd1;
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
							count_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// message schedule window and working variables
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				if (acc && in_ch.byte_valid)
					w_q[pos[5:2]][8 * (3 - pos[1:0]) +: 8] <= in_ch.msg_byte;
			end
			ST_PAD: begin
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				// second pass of a two-block pad: zeros and length only
				for (int b = 0; b < 64; b++) begin
					if (second_q) begin
						if (b < 56) w_q[b / 4][8 * (3 - b % 4) +: 8] <= 8'h00;
					end else if (b == int'(pad_pos_q)) begin
						w_q[b / 4][8 * (3 - b % 4) +: 8] <= PAD_BYTE;
					end else if (b > int'(pad_pos_q) && (b < 56 || need_two)) begin
						w_q[b / 4][8 * (3 - b % 4) +: 8] <= 8'h00;
					end
					if (b >= 56 && (second_q || !need_two))
						w_q[b / 4][8 * (3 - b % 4) +: 8] <= bits[8 * (63 - b) +: 8];
				end
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= w_new;
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
			end
			default: ;
		endcase
	end

	`SHA_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ch.ready, !out_ch.valid, "ready while output")
	`SHA_ASSERT_NXT(a_round_adv, clk, arst_n, state_q == ST_ROUND && round_q != 6'd63,
		state_q == ST_ROUND && round_q == $past(round_q) + 6'd1, "round counter skipped")
	`SHA_ASSERT_NXT(a_out_done, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.last_word,
		in_ch.ready && count_q == 64'd0, "no return to idle after digest")
endmodule

// ===== tb/sha256_stream_hasher_test.sv =====
// testbench for the sha-256 stream hasher: scoreboard class with a digest predictor
`timescale 1ns / 1ps
module sha256_stream_hasher_test;
	import sha_pkg::*;

	// one digest word as the output channel carries it
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_rec_t;

	// digest predictor and store of expected digest words
	class digest_scoreboard;
		word_t chain [8];
		logic [7:0] blk [64];
		logic [63:0] nbytes;
		digest_rec_t pending_words[$];
		int errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
			nbytes = '0;
		endfunction

		function word_t ror(word_t v, int s);
			return (v >> s) | (v << (32 - s));
		endfunction

		function void compress();
			word_t w [64];
			word_t v [8];
			word_t t1, t2;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			for (int t = 16; t < 64; t++)
				w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
					+ w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
			for (int i = 0; i < 8; i++) v[i] = chain[i];
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				for (int i = 7; i > 0; i--) v[i] = v[i-1];
				v[4] = v[4] + t1;
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] += v[i];
		endfunction

		// note an accepted input transaction
		function void note_byte(logic [7:0] b, logic bv, logic lst);
			int p;
			logic [63:0] bits;
			digest_rec_t r;
			if (bv) begin
				blk[nbytes[5:0]] = b;
				nbytes++;
				if (nbytes[5:0] == 0) compress();
			end
			if (!lst) return;
			p = int'(nbytes[5:0]);
			blk[p] = PAD_BYTE;
			p++;
			if (p > LEN_POS) begin
				for (int i = p; i < 64; i++) blk[i] = 8'h00;
				compress();
				for (int i = 0; i < LEN_POS; i++) blk[i] = 8'h00;
			end else begin
				for (int i = p; i < LEN_POS; i++) blk[i] = 8'h00;
			end
			bits = nbytes << 3;
			for (int k = 0; k < 8; k++) blk[LEN_POS + k] = bits[63 - 8*k -: 8];
			compress();
			for (int k = 0; k < 8; k++) begin
				r.digest_word = chain[k];
				r.word_index = 3'(k);
				r.last_word = (k == 7);
				pending_words.push_back(r);
			end
			restart();
		endfunction

		// compare an accepted digest word with the oldest expectation
		function void check_word(digest_rec_t got);
			digest_rec_t exp_r;
			if (pending_words.size() == 0) begin
				$error("unexpected digest word %h", got.digest_word);
				errors++;
				return;
			end
			exp_r = pending_words.pop_front();
			if (got.digest_word !== exp_r.digest_word) begin
				$error("digest_word: expected %h, actual %h", exp_r.digest_word, got.digest_word);
				errors++;
			end
			if (got.word_index !== exp_r.word_index) begin
				$error("word_index: expected %0d, actual %0d", exp_r.word_index, got.word_index);
				errors++;
			end
			if (got.last_word !== exp_r.last_word) begin
				$error("last_word: expected %0d, actual %0d", exp_r.last_word, got.last_word);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sha_byte_if in_ch();
	sha_digest_if out_ch();
	digest_scoreboard sb;
	bit no_idle;
	int quiet_cycles;
	int sink_gap;

	sha256_stream_hasher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// note transactions on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.msg_byte, in_ch.byte_valid, in_ch.last);
			if (out_ch.valid && out_ch.ready)
				sb.check_word({out_ch.digest_word, out_ch.word_index, out_ch.last_word});
		end
	end

	// digest sink with bursts of stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_gap <= 0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			sink_gap <= $urandom_range(1, 17) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("sha256_stream_hasher_test: done, errors");
			$finish;
		end
	end

	// send one transaction, with an optional idle burst first
	task automatic send_byte(logic [7:0] b, logic bv, logic lst);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.msg_byte <= b;
		in_ch.byte_valid <= bv;
		in_ch.last <= lst;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// a whole message of random bytes; the final byte may ride on last
	task automatic send_message(int len);
		bit on_last;
		on_last = (len > 0) && $urandom_range(0, 1);
		for (int i = 0; i < len - on_last; i++) begin
			if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
			send_byte(8'($urandom), 1'b1, 1'b0);
		end
		if (on_last) send_byte(8'($urandom), 1'b1, 1'b1);
		else send_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int sent;
		int len;
		sb = new();
		no_idle = 1'b0;
		quiet_cycles = 0;
		in_ch.valid = 1'b0;
		in_ch.msg_byte = '0;
		in_ch.byte_valid = 1'b0;
		in_ch.last = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// empty message, then extreme bytes, last with and without a byte
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b1, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b1);
		send_byte(8'hff, 1'b1, 1'b1);
		// random messages across padding boundaries (55, 56, 63, 64 bytes)
		sent = 0;
		while (sent < 210) begin
			case ($urandom_range(0, 5))
				0: len = 55 + $urandom_range(0, 10);
				1: len = 64 + $urandom_range(0, 70);
				default: len = $urandom_range(0, 20);
			endcase
			if (len > 210 - sent) len = 210 - sent;
			if (sent > 150) no_idle = 1'b1;
			send_message(len);
			sent += len + 1;
		end
		in_ch.valid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0)
			$display("sha256_stream_hasher_test: done, clean");
		else
			$display("sha256_stream_hasher_test: done, errors");
		$finish;
	end
endmodule

// ===== sha256_stream_hasher.f =====
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_byte_if.sv
rtl/sha_digest_if.sv
rtl/sha256_stream_hasher.sv
tb/sha256_stream_hasher_test.sv
